/* rtl/imm_pkg.sv */
// Shared types, codes and helpers for the integer matrix multiplier.
// No dependencies; used by imm_datapath, imm_ctrl and integer_matrix_multiply.
package imm_pkg;

    localparam int DATA_W      = 32;
    localparam int IDX_W       = 3;
    localparam int DIM_W       = 4;
    localparam int MAX_DIM_DEF = 8;
    localparam int TDATA_W     = 40;
    localparam int CFG_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    // input word kinds (s_tuser)
    localparam logic [1:0] MODE_LOAD_A = 2'd0;
    localparam logic [1:0] MODE_LOAD_B = 2'd1;
    localparam logic [1:0] MODE_START  = 2'd2;

    // config register indexes (paddr[3:2])
    localparam logic [1:0] REG_ROWS_A = 2'd0;
    localparam logic [1:0] REG_COLS_A = 2'd1;
    localparam logic [1:0] REG_ROWS_B = 2'd2;
    localparam logic [1:0] REG_COLS_B = 2'd3;

    typedef struct packed {
        logic [DIM_W-1:0] ra;
        logic [DIM_W-1:0] ca;
        logic [DIM_W-1:0] rb;
        logic [DIM_W-1:0] cb;
    } t_dims;

    typedef struct packed {
        logic             wr_a;
        logic             wr_b;
        logic             rd_en;
        logic             rd_first;
        logic [IDX_W-1:0] row_i;
        logic [IDX_W-1:0] col_j;
        logic [IDX_W-1:0] k;
        logic             load_out;
        logic             out_last;
        logic             load_err;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

    // 0 counts as 1, anything above max_d counts as max_d
    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d,
                                                   input logic [DIM_W-1:0] max_d);
        logic [DIM_W-1:0] r;
        r = d;
        if (d == '0) begin
            r = DIM_W'(1);
        end else if (d > max_d) begin
            r = max_d;
        end
        return r;
    endfunction

endpackage

/* rtl/imm_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module imm_ram #(
    parameter  int WIDTH  = 32,
    parameter  int DEPTH  = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/imm_datapath.sv */
// Datapath: A/B element stores, multiply-accumulate pipe, output word register.
// Depends on imm_pkg and imm_ram.
module imm_datapath #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  imm_pkg::t_cmd              i_cmd,
    input  logic [imm_pkg::IDX_W-1:0]  i_ld_row,
    input  logic [imm_pkg::IDX_W-1:0]  i_ld_col,
    input  logic [imm_pkg::DATA_W-1:0] i_ld_value,
    input  logic                       i_m_ready,
    output imm_pkg::t_stat             o_stat,
    output logic                       o_m_valid,
    output logic [imm_pkg::IDX_W-1:0]  o_out_row,
    output logic [imm_pkg::IDX_W-1:0]  o_out_col,
    output logic [imm_pkg::DATA_W-1:0] o_product,
    output logic                       o_last,
    output logic                       o_error
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic                       w_in_range;
    logic [ADDR_W-1:0]          w_waddr;
    logic [ADDR_W-1:0]          w_raddr_a;
    logic [ADDR_W-1:0]          w_raddr_b;
    logic [imm_pkg::DATA_W-1:0] w_a;
    logic [imm_pkg::DATA_W-1:0] w_b;

    logic                       r_v1, r_first1, r_v2, r_first2;
    logic [imm_pkg::DATA_W-1:0] r_prod;
    logic [imm_pkg::DATA_W-1:0] r_acc;

    logic                       r_out_valid;
    logic [imm_pkg::IDX_W-1:0]  r_out_row;
    logic [imm_pkg::IDX_W-1:0]  r_out_col;
    logic [imm_pkg::DATA_W-1:0] r_out_prod;
    logic                       r_out_last;
    logic                       r_out_err;

    // loads outside the store are dropped
    assign w_in_range = ({1'b0, i_ld_row} < imm_pkg::DIM_W'(MAX_DIM)) &&
                        ({1'b0, i_ld_col} < imm_pkg::DIM_W'(MAX_DIM));
    assign w_waddr   = ADDR_W'(int'(i_ld_row) * MAX_DIM + int'(i_ld_col));
    assign w_raddr_a = ADDR_W'(int'(i_cmd.row_i) * MAX_DIM + int'(i_cmd.k));
    assign w_raddr_b = ADDR_W'(int'(i_cmd.k) * MAX_DIM + int'(i_cmd.col_j));

    imm_ram #(.WIDTH(imm_pkg::DATA_W), .DEPTH(DEPTH)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_a && w_in_range),
        .i_waddr (w_waddr),
        .i_wdata (i_ld_value),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr_a),
        .o_rdata (w_a)
    );

    imm_ram #(.WIDTH(imm_pkg::DATA_W), .DEPTH(DEPTH)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_b && w_in_range),
        .i_waddr (w_waddr),
        .i_wdata (i_ld_value),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr_b),
        .o_rdata (w_b)
    );

    // read -> multiply -> accumulate, flags ride alongside
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1     <= 1'b0;
            r_first1 <= 1'b0;
            r_v2     <= 1'b0;
            r_first2 <= 1'b0;
            r_acc    <= '0;
        end else begin
            r_v1     <= i_cmd.rd_en;
            r_first1 <= i_cmd.rd_first;
            r_v2     <= r_v1;
            r_first2 <= r_first1;
            if (r_v2) begin
                r_acc <= (r_first2 ? '0 : r_acc) + r_prod;
            end
        end
    end

    // low 32 bits are the same for signed and unsigned operands
    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            r_prod <= w_a * w_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out || i_cmd.load_err) begin
            r_out_valid <= 1'b1;
        end else if (i_m_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_err) begin
            r_out_row  <= '0;
            r_out_col  <= '0;
            r_out_prod <= '0;
            r_out_last <= 1'b1;
            r_out_err  <= 1'b1;
        end else if (i_cmd.load_out) begin
            r_out_row  <= i_cmd.row_i;
            r_out_col  <= i_cmd.col_j;
            r_out_prod <= r_acc;
            r_out_last <= i_cmd.out_last;
            r_out_err  <= 1'b0;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_m_ready;
    assign o_m_valid = r_out_valid;
    assign o_out_row = r_out_row;
    assign o_out_col = r_out_col;
    assign o_product = r_out_prod;
    assign o_last    = r_out_last;
    assign o_error   = r_out_err;

endmodule

/* rtl/imm_ctrl.sv */
// Controller FSM: accepts words, walks i/j/k, sequences the MAC pipe and output.
// Depends on imm_pkg.
module imm_ctrl (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_valid,
    input  logic [1:0]                i_mode,
    input  imm_pkg::t_dims            i_dims,
    input  imm_pkg::t_stat            i_stat,
    output logic                      o_s_ready,
    output imm_pkg::t_cmd             o_cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_MAC   = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_EMIT  = 3'd3;
    localparam logic [2:0] ST_ERR   = 3'd4;

    logic [2:0]                r_state, n_state;
    logic [imm_pkg::IDX_W-1:0] r_i, n_i, r_j, n_j, r_k, n_k;
    logic                      r_wait, n_wait;
    logic                      w_accept;
    logic                      w_k_end, w_i_end, w_j_end;

    assign o_s_ready = (r_state == ST_IDLE);
    assign w_accept  = i_s_valid && o_s_ready;
    assign w_k_end   = ({1'b0, r_k} == i_dims.rb - imm_pkg::DIM_W'(1));
    assign w_i_end   = ({1'b0, r_i} == i_dims.ra - imm_pkg::DIM_W'(1));
    assign w_j_end   = ({1'b0, r_j} == i_dims.cb - imm_pkg::DIM_W'(1));

    always_comb begin
        n_state = r_state;
        n_i     = r_i;
        n_j     = r_j;
        n_k     = r_k;
        n_wait  = r_wait;
        o_cmd   = '0;
        o_cmd.row_i    = r_i;
        o_cmd.col_j    = r_j;
        o_cmd.k        = r_k;
        o_cmd.rd_first = (r_k == '0);
        o_cmd.out_last = w_i_end && w_j_end;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.wr_a = (i_mode == imm_pkg::MODE_LOAD_A);
                    o_cmd.wr_b = (i_mode == imm_pkg::MODE_LOAD_B);
                    if (i_mode == imm_pkg::MODE_START) begin
                        n_i = '0;
                        n_j = '0;
                        n_k = '0;
                        n_state = (i_dims.ca != i_dims.rb) ? ST_ERR : ST_MAC;
                    end
                end
            end
            ST_MAC: begin
                o_cmd.rd_en = 1'b1;
                n_k = r_k + imm_pkg::IDX_W'(1);
                if (w_k_end) begin
                    n_wait  = 1'b0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_wait = 1'b1;
                if (r_wait) begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_k = '0;
                    if (w_i_end && w_j_end) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_MAC;
                        if (w_j_end) begin
                            n_j = '0;
                            n_i = r_i + imm_pkg::IDX_W'(1);
                        end else begin
                            n_j = r_j + imm_pkg::IDX_W'(1);
                        end
                    end
                end
            end
            ST_ERR: begin
                if (i_stat.out_free) begin
                    o_cmd.load_err = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_i     <= '0;
            r_j     <= '0;
            r_k     <= '0;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_i     <= n_i;
            r_j     <= n_j;
            r_k     <= n_k;
            r_wait  <= n_wait;
        end
    end

`ifndef ASSERT_OFF
    a_one_output_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(o_cmd.load_out && o_cmd.load_err))
        else $error("product and error word loaded together");

    a_load_only_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_out || o_cmd.load_err) |-> i_stat.out_free)
        else $error("output word overwritten before taken");

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.load_out && o_cmd.out_last) |=> (r_state == ST_IDLE))
        else $error("run did not end after last product");

    a_k_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MAC) |-> ({1'b0, r_k} < i_dims.rb))
        else $error("inner index beyond inner dimension");
`endif

endmodule

/* rtl/integer_matrix_multiply.sv */
// Integer matrix multiplier, C = A x B, signed 32-bit elements, sums wrap to 32 bits.
// A start word gives ra*cb product words; each is made by ca
// multiply-accumulates through the one read port per store, a pipe drain and one
// output load, and a run is held while m_tready stalls. A dimension mismatch (ca != rb)
// gives one error word, loaded once the output register is free.
// Reset (sync, active low) clears control and sets all dimensions to 1; stores are not cleared.
module integer_matrix_multiply #(
    parameter int MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // input stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [imm_pkg::TDATA_W-1:0]     s_tdata,  // row[2:0], col[5:3], value[37:6], pad
    input  logic [1:0]                      s_tuser,  // mode[1:0]
    // output stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [imm_pkg::TDATA_W-1:0]     m_tdata,  // out_row[2:0], out_col[5:3],
                                                      // product[37:6], pad
    output logic                            m_tlast,
    output logic                            m_tuser,  // error
    // config port
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [imm_pkg::CFG_ADDR_W-1:0]  paddr,
    input  logic [imm_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [imm_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    logic [imm_pkg::DIM_W-1:0]  r_rows_a, r_cols_a, r_rows_b, r_cols_b;
    logic [imm_pkg::DIM_W-1:0]  w_rd_reg;
    logic [imm_pkg::DIM_W-1:0]  w_max;
    logic [1:0]                 w_reg_idx;
    logic                       w_cfg_wr;
    imm_pkg::t_dims             w_dims;
    imm_pkg::t_cmd              w_cmd;
    imm_pkg::t_stat             w_stat;
    logic [imm_pkg::IDX_W-1:0]  w_out_row, w_out_col;
    logic [imm_pkg::DATA_W-1:0] w_product;

    // ---- configuration registers ----
    assign pready    = 1'b1;
    assign w_reg_idx = paddr[3:2];
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a <= imm_pkg::DIM_W'(1);
            r_cols_a <= imm_pkg::DIM_W'(1);
            r_rows_b <= imm_pkg::DIM_W'(1);
            r_cols_b <= imm_pkg::DIM_W'(1);
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                imm_pkg::REG_ROWS_A: r_rows_a <= pwdata[imm_pkg::DIM_W-1:0];
                imm_pkg::REG_COLS_A: r_cols_a <= pwdata[imm_pkg::DIM_W-1:0];
                imm_pkg::REG_ROWS_B: r_rows_b <= pwdata[imm_pkg::DIM_W-1:0];
                imm_pkg::REG_COLS_B: r_cols_b <= pwdata[imm_pkg::DIM_W-1:0];
                default:             r_cols_b <= r_cols_b;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            imm_pkg::REG_ROWS_A: w_rd_reg = r_rows_a;
            imm_pkg::REG_COLS_A: w_rd_reg = r_cols_a;
            imm_pkg::REG_ROWS_B: w_rd_reg = r_rows_b;
            imm_pkg::REG_COLS_B: w_rd_reg = r_cols_b;
            default:             w_rd_reg = '0;
        endcase
    end
    assign prdata = imm_pkg::APB_DATA_W'(w_rd_reg);

    // Dimensions used by the run: zero counts as one, oversize counts as MAX_DIM.
    assign w_max     = imm_pkg::DIM_W'(MAX_DIM);
    assign w_dims.ra = imm_pkg::clamp_dim(r_rows_a, w_max);
    assign w_dims.ca = imm_pkg::clamp_dim(r_cols_a, w_max);
    assign w_dims.rb = imm_pkg::clamp_dim(r_rows_b, w_max);
    assign w_dims.cb = imm_pkg::clamp_dim(r_cols_b, w_max);

    // ---- controller ----
    imm_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (s_tvalid),
        .i_mode    (s_tuser),
        .i_dims    (w_dims),
        .i_stat    (w_stat),
        .o_s_ready (s_tready),
        .o_cmd     (w_cmd)
    );

    // ---- datapath: stores, MAC pipe, output word ----
    imm_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .i_ld_row   (s_tdata[2:0]),
        .i_ld_col   (s_tdata[5:3]),
        .i_ld_value (s_tdata[37:6]),
        .i_m_ready  (m_tready),
        .o_stat     (w_stat),
        .o_m_valid  (m_tvalid),
        .o_out_row  (w_out_row),
        .o_out_col  (w_out_col),
        .o_product  (w_product),
        .o_last     (m_tlast),
        .o_error    (m_tuser)
    );

    assign m_tdata = {2'b00, w_product, w_out_col, w_out_row};

endmodule
